// ===== hdl/lzss_pkg.sv =====
// Shared types and constants for the LZSS decompressor.
`timescale 1ns / 1ps

package lzss_pkg;

    // Flag register value right after a flag byte is loaded: marker bit above the eight control bits
    localparam logic [8:0] FLAG_MARK  = 9'h100;
    // Flag register value when no control bits remain
    localparam logic [8:0] FLAG_EMPTY = 9'h001;

    // Commands from the controller to the datapath; all but copy_run are qualified by the handshake
    typedef struct packed {
        logic load_flag;    // load a new flag byte
        logic clear_flag;   // drop the remaining control bits (end of stream)
        logic consume_flag; // shift out one control bit
        logic write_lit;    // emit the input byte as a literal
        logic load_low;     // hold the low byte of a match
        logic start_copy;   // set up a match copy from the high byte
        logic copy_run;     // advance the match copy
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic flag_bit;     // current control bit
        logic flag_end;     // this control bit is the last one of its flag byte
        logic out_free;     // output register can take an item this cycle
        logic copy_done;    // final byte of the match leaves this cycle
    } sts_t;

endpackage

// ===== hdl/lzss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/lzss_ctrl.sv =====
// Parser and copy sequencer state machine for the LZSS decompressor.
`timescale 1ns / 1ps

module lzss_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_tlast,
    input  lzss_pkg::sts_t sts,
    output lzss_pkg::cmd_t cmd
);
    import lzss_pkg::*;

    localparam logic [1:0] ST_FLAG = 2'd0;
    localparam logic [1:0] ST_DATA = 2'd1;
    localparam logic [1:0] ST_HIGH = 2'd2;
    localparam logic [1:0] ST_COPY = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;
    logic       accept;
    logic [1:0] after_bit;

    // A literal needs room in the output register; otherwise only a copy stalls
    assign s_tready = (state_reg != ST_COPY) &&
                      (!(state_reg == ST_DATA && sts.flag_bit) || sts.out_free);
    assign accept   = s_tvalid && s_tready;
    assign after_bit = (s_tlast || sts.flag_end) ? ST_FLAG : ST_DATA;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_FLAG: begin
                if (accept) begin
                    if (s_tlast) begin
                        cmd.clear_flag = 1'b1;
                    end else begin
                        cmd.load_flag = 1'b1;
                        state_next    = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (accept) begin
                    cmd.clear_flag = s_tlast;
                    if (sts.flag_bit) begin
                        cmd.write_lit    = 1'b1;
                        cmd.consume_flag = 1'b1;
                        state_next       = after_bit;
                    end else begin
                        cmd.load_low = 1'b1;
                        state_next   = s_tlast ? ST_FLAG : ST_HIGH;
                    end
                end
            end
            ST_HIGH: begin
                if (accept) begin
                    cmd.start_copy   = 1'b1;
                    cmd.consume_flag = 1'b1;
                    cmd.clear_flag   = s_tlast;
                    ret_next         = after_bit;
                    state_next       = ST_COPY;
                end
            end
            ST_COPY: begin
                cmd.copy_run = 1'b1;
                if (sts.copy_done) begin
                    state_next = ret_reg;
                end
            end
            default: begin
                state_next = ST_FLAG;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FLAG;
            ret_reg   <= ST_FLAG;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

// ===== hdl/lzss_datapath.sv =====
// Flag register, history window, match copy engine and output register.
`timescale 1ns / 1ps

module lzss_datapath #(
    parameter int WINDOW_BITS = 12,
    parameter int LENGTH_BITS = 4,
    parameter int MIN_MATCH   = 3
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [7:0]     in_byte,
    input  lzss_pkg::cmd_t cmd,
    output lzss_pkg::sts_t sts,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);
    import lzss_pkg::*;

    localparam int WIN_DEPTH = 1 << WINDOW_BITS;
    localparam int WORD_W    = WINDOW_BITS + LENGTH_BITS;
    localparam int MAX_LEN   = MIN_MATCH + (1 << LENGTH_BITS) - 1;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);

    logic [8:0]             flag_reg, flag_next;
    logic [7:0]             low_reg;
    logic [WINDOW_BITS-1:0] wp_reg;
    logic                   wrapped_reg;
    logic [WINDOW_BITS-1:0] src_reg;
    logic [CNT_W-1:0]       reads_left_reg;
    logic [CNT_W-1:0]       bytes_left_reg;
    logic                   have_reg;
    logic                   hit_reg;
    logic [7:0]             byp_reg;
    logic                   vld_reg;
    logic                   m_tvalid_reg;
    logic [7:0]             m_tdata_reg;
    logic                   m_tlast_reg;

    logic [15:0]            word;
    logic [WORD_W-1:0]      word_ext;
    logic [WINDOW_BITS-1:0] field;
    logic [LENGTH_BITS-1:0] code;
    logic [CNT_W-1:0]       len;
    logic                   out_free;
    logic                   can_emit;
    logic                   issue;
    logic                   emit;
    logic [7:0]             ram_q;
    logic [7:0]             rd_byte;
    logic [7:0]             wdata;
    logic                   last_bit;

    // Match word: low byte first, offset in the low bits, length code above
    assign word     = {in_byte, low_reg};
    assign word_ext = WORD_W'(word);
    assign field    = word_ext[WINDOW_BITS-1:0];
    assign code     = word_ext[WORD_W-1 -: LENGTH_BITS];
    assign len      = CNT_W'(code) + CNT_W'(MIN_MATCH);

    assign out_free = !m_tvalid_reg || m_tready;
    assign can_emit = cmd.copy_run && have_reg && out_free;
    // Read one byte ahead of the write; refill as soon as the held byte leaves
    assign issue    = cmd.copy_run && (reads_left_reg != '0) && (!have_reg || can_emit);
    assign emit     = cmd.write_lit || can_emit;

    // Entries not yet written since reset read as zero; same-cycle writes forward
    assign rd_byte  = hit_reg ? byp_reg : (vld_reg ? ram_q : 8'h00);
    assign wdata    = cmd.write_lit ? in_byte : rd_byte;
    assign last_bit = cmd.write_lit || (bytes_left_reg == CNT_W'(1));

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (WIN_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (emit),
        .waddr (wp_reg),
        .wdata (wdata),
        .re    (issue),
        .raddr (src_reg),
        .rdata (ram_q)
    );

    always_comb begin
        flag_next = flag_reg;
        if (cmd.clear_flag) begin
            flag_next = FLAG_EMPTY;
        end else if (cmd.load_flag) begin
            flag_next = FLAG_MARK | {1'b0, in_byte};
        end else if (cmd.consume_flag) begin
            flag_next = {1'b0, flag_reg[8:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg       <= FLAG_EMPTY;
            low_reg        <= 8'h00;
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            reads_left_reg <= '0;
            bytes_left_reg <= '0;
            have_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            flag_reg <= flag_next;
            if (cmd.load_low) begin
                low_reg <= in_byte;
            end
            if (emit) begin
                wp_reg <= wp_reg + 1'b1;
                if (wp_reg == '1) begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (cmd.start_copy) begin
                reads_left_reg <= len;
                bytes_left_reg <= len;
                have_reg       <= 1'b0;
            end else begin
                if (issue) begin
                    reads_left_reg <= reads_left_reg - 1'b1;
                end
                if (can_emit) begin
                    bytes_left_reg <= bytes_left_reg - 1'b1;
                end
                if (issue) begin
                    have_reg <= 1'b1;
                end else if (can_emit) begin
                    have_reg <= 1'b0;
                end
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start_copy) begin
            src_reg <= wp_reg + field;
        end else if (issue) begin
            src_reg <= src_reg + 1'b1;
        end
        if (issue) begin
            hit_reg <= emit && (src_reg == wp_reg);
            byp_reg <= wdata;
            vld_reg <= wrapped_reg || (src_reg < wp_reg);
        end
        if (emit) begin
            m_tdata_reg <= wdata;
            m_tlast_reg <= last_bit;
        end
    end

    assign sts.flag_bit  = flag_reg[0];
    assign sts.flag_end  = (flag_reg[8:2] == 7'd0);
    assign sts.out_free  = out_free;
    assign sts.copy_done = can_emit && (bytes_left_reg == CNT_W'(1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== hdl/lzss_decompressor.sv =====
// Top level of the LZSS decompressor: parser controller plus history datapath.
//
// Usage:
//   Feed compressed bytes on the s_ channel, one item per handshake; s_tlast marks the
//   final byte of a stream. Decoded bytes leave on the m_ channel; m_tlast is set on
//   the last byte produced by one input item (every literal, the final byte of a match).
//   A flag byte or a match low byte produces nothing.
// Flow:
//   A literal enters the output register and appears in the cycle after it is accepted.
//   For a match, the high byte starts a copy of L bytes (MIN_MATCH to MIN_MATCH +
//   2**LENGTH_BITS - 1); the first byte is read from the history into a register, then
//   enters the output register; the rest follow one per cycle while m_tready allows, set
//   by the single history read port read one byte ahead of the write. s_tready stays low
//   during the copy; other items can be taken back to back, a literal only with output room.
// Reset:
//   aresetn low clears the parser, write pointer and output register. The history is
//   not swept: a wrap mark and the write pointer tell written entries from unwritten
//   ones, which read as zero, so the block is ready the cycle after reset.
// Stall:
//   When m_tready is low the output item holds and the copy pauses; an input item that
//   produces no output is still taken.
`timescale 1ns / 1ps

module lzss_decompressor #(
    parameter int WINDOW_BITS = 12,
    parameter int LENGTH_BITS = 4,
    parameter int MIN_MATCH   = 3
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last_of_run
);
    import lzss_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Parser: flag byte, literal or match low byte, match high byte, copy
    lzss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    // History window, copy engine and output register
    lzss_datapath #(
        .WINDOW_BITS (WINDOW_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .MIN_MATCH   (MIN_MATCH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_byte  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hdl/lzss_checker.sv =====
// Port-level assertions for the LZSS decompressor and their bind.
`timescale 1ns / 1ps

module lzss_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // Hold a stalled output item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // Come out of reset empty and ready for a flag byte
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    // Inside a match the next byte follows each taken byte without a bubble
    a_copy_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("bubble inside a match copy");

    // Take no input while a match is still being copied out
    a_copy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted during a match copy");

endmodule

bind lzss_decompressor lzss_checker u_lzss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the LZSS decompressor: directed rows, random streams, stalls.
`timescale 1ns / 1ps

module testbench;
    import lzss_pkg::*;

    localparam int WIN_SIZE   = 4096;
    localparam int MIN_LEN    = 3;
    localparam int STALL_MAX  = 2000;   // cycles without any handshake before giving up
    localparam int DRAIN_WAIT = 40;     // settle time after the last expected item
    localparam int RAND_ITEMS = 30;     // minimum count of random input items per idling phase

    typedef enum logic [1:0] {WANT_FLAG, WANT_LOW, WANT_HIGH} parse_e;

    // One input item; n_fixed >= 0 gives the number of typed results, all equal to fixed_val
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        int         n_fixed;
        logic [7:0] fixed_val;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Shadow of the decoder state
    logic [7:0]  hist_mem [WIN_SIZE];
    logic [11:0] wr_ptr;
    logic [8:0]  ctl_bits;
    parse_e      parse_st;
    logic [7:0]  low_hold;

    out_item_t   run_q[$];      // bytes decoded from the latest input item
    out_item_t   decoded_q[$];  // decoded bytes still to leave the block
    in_item_t    stim_q[$];

    int err_cnt = 0;
    int quiet_cycles = 0;
    int rcv_stall = 0;

    // Directed rows: extremes, overlap, window-size distance, ends of stream
    in_item_t dir_rows [25] = '{
        '{8'h00, 1'b0,  0, 8'h00},   // flag: eight matches
        '{8'h00, 1'b0,  0, 8'h00},   // match low
        '{8'h00, 1'b0,  3, 8'h00},   // shortest match, full-window distance, nothing written yet
        '{8'hFF, 1'b0,  0, 8'h00},
        '{8'hFF, 1'b1, 18, 8'h00},   // longest match, distance one, repeats a zero; stream ends
        '{8'hFF, 1'b0,  0, 8'h00},   // flag: eight literals
        '{8'h00, 1'b0,  1, 8'h00},
        '{8'hFF, 1'b0,  1, 8'hFF},
        '{8'hA5, 1'b0,  1, 8'hA5},
        '{8'h5A, 1'b0,  1, 8'h5A},
        '{8'h01, 1'b0,  1, 8'h01},
        '{8'h80, 1'b0,  1, 8'h80},
        '{8'h7E, 1'b0,  1, 8'h7E},
        '{8'h3C, 1'b0,  1, 8'h3C},
        '{8'h55, 1'b0,  0, 8'h00},   // flag: literal and match alternate
        '{8'h12, 1'b0,  1, 8'h12},
        '{8'hFE, 1'b0,  0, 8'h00},
        '{8'h0F, 1'b0, -1, 8'h00},   // distance two, overlapping copy
        '{8'h34, 1'b0,  1, 8'h34},
        '{8'hFF, 1'b1,  0, 8'h00},   // stream ends on a match low byte: pair dropped
        '{8'hAA, 1'b1,  0, 8'h00},   // flag byte as last byte
        '{8'hFE, 1'b0,  0, 8'h00},
        '{8'h00, 1'b0,  0, 8'h00},
        '{8'h10, 1'b0, -1, 8'h00},   // offset field zero: reads one window back
        '{8'h77, 1'b1,  1, 8'h77}
    };

    int sender_idle [4] = '{0, 79, 0, 27};
    int recv_idle   [4] = '{0, 0, 79, 27};

    lzss_decompressor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] in_byte
        .s_tlast  (s_tlast),    // in_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_byte
        .m_tlast  (m_tlast)     // last_of_run
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Shift out one control bit; fall back to a flag byte when none are left
    task automatic drop_ctl_bit();
        ctl_bits = ctl_bits >> 1;
        parse_st = (ctl_bits <= FLAG_EMPTY) ? WANT_FLAG : WANT_LOW;
    endtask

    // Decode one compressed byte into run_q and advance the shadow state
    task automatic decode_byte(input logic [7:0] din, input logic dlast);
        logic [15:0] word;
        logic [11:0] src;
        logic [7:0]  v;
        int          len;
        run_q.delete();
        case (parse_st)
            WANT_LOW: begin
                if (ctl_bits[0]) begin
                    hist_mem[wr_ptr] = din;
                    wr_ptr = wr_ptr + 12'd1;
                    run_q.push_back('{din, 1'b1});
                    drop_ctl_bit();
                end else begin
                    low_hold = din;
                    parse_st = WANT_HIGH;
                end
            end
            WANT_HIGH: begin
                word = {din, low_hold};
                len = int'(word[15:12]) + MIN_LEN;
                for (int i = 0; i < len; i++) begin
                    src = wr_ptr + word[11:0];
                    v = hist_mem[src];
                    hist_mem[wr_ptr] = v;
                    wr_ptr = wr_ptr + 12'd1;
                    run_q.push_back('{v, (i == len - 1)});
                end
                drop_ctl_bit();
            end
            default: begin
                ctl_bits = FLAG_MARK | {1'b0, din};
                parse_st = WANT_LOW;
            end
        endcase
        if (dlast) begin
            parse_st = WANT_FLAG;
            ctl_bits = FLAG_EMPTY;
        end
    endtask

    function automatic void add_item(input logic [7:0] d, input logic l);
        stim_q.push_back('{d, l, -1, 8'h00});
    endfunction

    // Build well-formed streams with random content, plus some stray bytes and cut-off streams
    task automatic build_streams(input int count);
        logic [7:0]  flag;
        logic [15:0] word;
        logic        stop;
        logic        cut_pair;
        while (stim_q.size() < count) begin
            if ($urandom_range(9) == 0) begin
                add_item(8'($urandom), 1'($urandom_range(1)));
                continue;
            end
            flag = 8'($urandom);
            stop = ($urandom_range(15) == 0);
            add_item(flag, stop);
            if (stop)
                continue;
            for (int k = 0; k < 8; k++) begin
                stop = ($urandom_range(23) == 0);
                if (flag[k]) begin
                    add_item(8'($urandom), stop);
                end else begin
                    word[15:12] = 4'($urandom);
                    // Favor short distances so copies hit written history
                    if ($urandom_range(1))
                        word[11:0] = 12'hFFF - 12'($urandom_range(63));
                    else
                        word[11:0] = 12'($urandom);
                    cut_pair = stop && ($urandom_range(1) == 1);
                    add_item(word[7:0], cut_pair);
                    if (!cut_pair)
                        add_item(word[15:8], stop);
                end
                if (stop)
                    break;
            end
        end
    endtask

    // Present every queued item, idling at random; optionally hold off halfway until drained
    task automatic drive_items(input int idle_pct, input bit hold_mid);
        in_item_t it;
        int       n_total;
        n_total = stim_q.size();
        for (int k = 0; k < n_total; k++) begin
            it = stim_q.pop_front();
            if (hold_mid && k == n_total / 2) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (decoded_q.size() != 0)
                    @(posedge aclk);
            end
            while ($urandom_range(99) < idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= it.data;
            s_tlast  <= it.last;
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
            decode_byte(it.data, it.last);
            if (it.n_fixed >= 0) begin
                for (int j = 0; j < it.n_fixed; j++)
                    decoded_q.push_back('{it.fixed_val, (j == it.n_fixed - 1)});
            end else begin
                foreach (run_q[j])
                    decoded_q.push_back(run_q[j]);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (decoded_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Receiver: stall at the rate of the current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_stall);
    end

    // Compare every accepted output item with the oldest expectation
    always @(posedge aclk) begin : check_out
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected output item: out_byte %h last_of_run %b", m_tdata, m_tlast);
                err_cnt++;
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.data) begin
                    $error("out_byte: expected %h, got %h", want.data, m_tdata);
                    err_cnt++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_run: expected %b, got %b", want.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Count cycles in which no item moves on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_MAX);
        $display("[lzss_decompressor] ERROR");
        $finish;
    end

    initial begin
        foreach (hist_mem[i])
            hist_mem[i] = 8'h00;
        wr_ptr   = '0;
        ctl_bits = FLAG_EMPTY;
        parse_st = WANT_FLAG;
        low_hold = 8'h00;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows with no idling
        foreach (dir_rows[i])
            stim_q.push_back(dir_rows[i]);
        drive_items(0, 1'b0);
        wait_drained();

        // Random streams under each idling pattern; the slow-sender phase also drains mid-way
        for (int p = 0; p < 4; p++) begin
            rcv_stall = recv_idle[p];
            build_streams(RAND_ITEMS);
            drive_items(sender_idle[p], (p == 1));
            wait_drained();
        end

        if (err_cnt == 0 && decoded_q.size() == 0)
            $display("[lzss_decompressor] OK");
        else
            $display("[lzss_decompressor] ERROR");
        $finish;
    end

endmodule

// ===== lzss_decompressor.f =====
hdl/lzss_pkg.sv
hdl/lzss_ram.sv
hdl/lzss_ctrl.sv
hdl/lzss_datapath.sv
hdl/lzss_decompressor.sv
hdl/lzss_checker.sv
tb/testbench.sv
